// File: sv/sckb_pkg.sv
// Shared constants, types and the key translation table for the scancode key buffer.
`default_nettype none

package sckb_pkg;

	// Character queue geometry.
	localparam int QUEUE_DEPTH = 4096;
	localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [QADDR_W:0]   QDEPTH_WRAP = (QADDR_W + 1)'(QUEUE_DEPTH);
	localparam logic [QADDR_W-1:0] QHEAD_LAST  = QADDR_W'(QUEUE_DEPTH - 1);
	localparam logic [QCNT_W-1:0]  QDEPTH_CNT  = QCNT_W'(QUEUE_DEPTH);

	// Request kinds.
	localparam logic KIND_SCAN = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// Result kinds.
	localparam logic RK_ECHO = 1'b0;
	localparam logic RK_READ = 1'b1;

	// Scancodes with special handling.
	localparam logic [6:0] SC_LSHIFT = 7'd42;
	localparam logic [6:0] SC_RSHIFT = 7'd54;
	localparam logic [7:0] SC_CAPS   = 8'd58;
	localparam logic [7:0] SC_BKSP   = 8'd14;

	// Table offset of the shifted half.
	localparam logic [8:0] SHIFT_OFS = 9'd90;

	// Shift count limits.
	localparam logic signed [4:0] SHIFT_MAX = 5'sd8;
	localparam logic signed [4:0] SHIFT_MIN = -5'sd8;

	// Characters used by the backspace echo.
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// One result as handed from the decode stage to the output stage.
	typedef struct packed {
		logic              load;
		logic              kind;
		logic [7:0]        chr;
		logic              rvalid;
		logic [QCNT_W-1:0] fill;
		logic              flushed;
		logic              triple;
	} sckb_load_t;

	// Set-1 translation table; the upper half holds the shifted characters.
	// Indices past the end of the table read zero.
	function automatic logic [7:0] rom_lookup(input logic [8:0] idx);
		logic [7:0] c;
		case (idx)
			9'd1:   c = 8'h1B;
			9'd2:   c = "1";
			9'd3:   c = "2";
			9'd4:   c = "3";
			9'd5:   c = "4";
			9'd6:   c = "5";
			9'd7:   c = "6";
			9'd8:   c = "7";
			9'd9:   c = "8";
			9'd10:  c = "9";
			9'd11:  c = "0";
			9'd12:  c = "-";
			9'd13:  c = "=";
			9'd14:  c = 8'h08;
			9'd15:  c = 8'h09;
			9'd16:  c = "q";
			9'd17:  c = "w";
			9'd18:  c = "e";
			9'd19:  c = "r";
			9'd20:  c = "t";
			9'd21:  c = "y";
			9'd22:  c = "u";
			9'd23:  c = "i";
			9'd24:  c = "o";
			9'd25:  c = "p";
			9'd26:  c = "[";
			9'd27:  c = "]";
			9'd28:  c = 8'h0A;
			9'd30:  c = "a";
			9'd31:  c = "s";
			9'd32:  c = "d";
			9'd33:  c = "f";
			9'd34:  c = "g";
			9'd35:  c = "h";
			9'd36:  c = "j";
			9'd37:  c = "k";
			9'd38:  c = "l";
			9'd39:  c = ";";
			9'd40:  c = 8'h27;
			9'd41:  c = 8'h60;
			9'd43:  c = 8'h5C;
			9'd44:  c = "z";
			9'd45:  c = "x";
			9'd46:  c = "c";
			9'd47:  c = "v";
			9'd48:  c = "b";
			9'd49:  c = "n";
			9'd50:  c = "m";
			9'd51:  c = ",";
			9'd52:  c = ".";
			9'd53:  c = "/";
			9'd55:  c = "*";
			9'd57:  c = " ";
			9'd74:  c = "-";
			9'd78:  c = "+";
			9'd91:  c = 8'h1B;
			9'd92:  c = "!";
			9'd93:  c = "@";
			9'd94:  c = "#";
			9'd95:  c = "$";
			9'd96:  c = "%";
			9'd97:  c = "^";
			9'd98:  c = "&";
			9'd99:  c = "*";
			9'd100: c = "(";
			9'd101: c = ")";
			9'd102: c = "_";
			9'd103: c = "+";
			9'd104: c = 8'h08;
			9'd105: c = 8'h09;
			9'd106: c = "Q";
			9'd107: c = "W";
			9'd108: c = "E";
			9'd109: c = "R";
			9'd110: c = "T";
			9'd111: c = "Y";
			9'd112: c = "U";
			9'd113: c = "I";
			9'd114: c = "O";
			9'd115: c = "P";
			9'd116: c = "{";
			9'd117: c = "}";
			9'd118: c = 8'h0A;
			9'd120: c = "A";
			9'd121: c = "S";
			9'd122: c = "D";
			9'd123: c = "F";
			9'd124: c = "G";
			9'd125: c = "H";
			9'd126: c = "J";
			9'd127: c = "K";
			9'd128: c = "L";
			9'd129: c = ":";
			9'd130: c = 8'h22;
			9'd131: c = "~";
			9'd133: c = "|";
			9'd134: c = "Z";
			9'd135: c = "X";
			9'd136: c = "C";
			9'd137: c = "V";
			9'd138: c = "B";
			9'd139: c = "N";
			9'd140: c = "M";
			9'd141: c = "<";
			9'd142: c = ">";
			9'd143: c = "?";
			9'd145: c = "*";
			9'd147: c = " ";
			9'd164: c = "-";
			9'd168: c = "+";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Reduce a queue position sum below the depth.
	function automatic logic [QADDR_W-1:0] q_wrap(input logic [QADDR_W:0] sum);
		logic [QADDR_W:0] r;
		r = (sum >= QDEPTH_WRAP) ? (sum - QDEPTH_WRAP) : sum;
		return r[QADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: sv/sckb_ram.sv
// Generic simple dual-port RAM with a registered read port.
`default_nettype none

module sckb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/sckb_core.sv
// Request register, key decode, shift and caps state, and queue pointer control.
`default_nettype none

module sckb_core import sckb_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output      logic               req_ready,
	input  wire logic               kind,
	input  wire logic [7:0]         scan_code,
	input  wire logic               emit_free,
	output      sckb_load_t         ld,
	output      logic               ram_we,
	output      logic [QADDR_W-1:0] ram_waddr,
	output      logic [7:0]         ram_wdata,
	output      logic               ram_re,
	output      logic [QADDR_W-1:0] ram_raddr
);

	logic              valid_s1;
	logic              kind_s1;
	logic [7:0]        code_s1;

	logic signed [4:0] shift_q;
	logic              caps_q;
	logic [QADDR_W-1:0] head_q;
	logic [QCNT_W-1:0]  count_q;

	logic is_read, is_rel, is_shift_key, is_caps, is_bs, is_char;
	logic has_result, go, push, pop, full;
	logic shift_up, shift_dn;
	logic [8:0]        rom_idx;
	logic [7:0]        push_char;
	logic [QCNT_W-1:0] count_inc, count_d;
	logic [QADDR_W-1:0] head_d, head_inc;
	logic signed [4:0] shift_d;

	always_comb begin
		is_read      = (kind_s1 == KIND_READ);
		is_rel       = code_s1[7];
		is_shift_key = (code_s1[6:0] == SC_LSHIFT) || (code_s1[6:0] == SC_RSHIFT);
		is_caps      = !is_read && (code_s1 == SC_CAPS);
		is_bs        = !is_read && (code_s1 == SC_BKSP);
		is_char      = !is_read && !is_rel && !is_shift_key && !is_caps && !is_bs;
		has_result   = is_read || is_bs || is_char;
		go           = valid_s1 && (!has_result || emit_free);
		req_ready    = !valid_s1 || go;

		// Shift keys on press and release; caps lock moves the count with its toggle.
		shift_up = !is_read && ((!is_rel && is_shift_key) || (is_caps && !caps_q));
		shift_dn = !is_read && ((is_rel && is_shift_key) || (is_caps && caps_q));
		shift_d  = shift_q;
		if (shift_up && (shift_q != SHIFT_MAX)) begin
			shift_d = shift_q + 5'sd1;
		end else if (shift_dn && (shift_q != SHIFT_MIN)) begin
			shift_d = shift_q - 5'sd1;
		end

		rom_idx   = {1'b0, code_s1} + (((!shift_q[4]) && (shift_q[3:0] != 4'd0)) ?
			SHIFT_OFS : 9'd0);
		push_char = is_bs ? CH_BS : rom_lookup(rom_idx);

		push      = is_bs || is_char;
		pop       = is_read && (count_q != '0);
		count_inc = count_q + QCNT_W'(1);
		full      = (count_inc == QDEPTH_CNT);
		head_inc  = (head_q == QHEAD_LAST) ? '0 : head_q + QADDR_W'(1);

		head_d  = head_q;
		count_d = count_q;
		if (push) begin
			count_d = full ? '0 : count_inc;
			head_d  = full ? '0 : head_q;
		end else if (pop) begin
			count_d = count_q - QCNT_W'(1);
			head_d  = head_inc;
		end

		ram_we    = go && push;
		ram_waddr = q_wrap({1'b0, head_q} + {1'b0, count_q[QADDR_W-1:0]});
		ram_wdata = push_char;
		ram_re    = go && pop;
		ram_raddr = head_q;

		ld.load    = go && has_result;
		ld.kind    = is_read ? RK_READ : RK_ECHO;
		ld.chr     = is_read ? 8'h00 : push_char;
		ld.rvalid  = pop;
		ld.fill    = count_d;
		ld.flushed = push && full;
		ld.triple  = is_bs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			shift_q  <= '0;
			caps_q   <= 1'b0;
			head_q   <= '0;
			count_q  <= '0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (go) begin
				shift_q <= shift_d;
				head_q  <= head_d;
				count_q <= count_d;
				if (is_caps) begin
					caps_q <= !caps_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			kind_s1 <= kind;
			code_s1 <= scan_code;
		end
	end

endmodule

`default_nettype wire

// File: sv/sckb_emit.sv
// Result register that presents one result, or the three-beat backspace echo.
`default_nettype none

module sckb_emit import sckb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sckb_load_t        ld,
	input  wire logic [7:0]        ram_rdata,
	output      logic              emit_free,
	output      logic              rsp_valid,
	input  wire logic              rsp_ready,
	output      logic              result_kind,
	output      logic [7:0]        char_value,
	output      logic              read_valid,
	output      logic [QCNT_W-1:0] fill_level,
	output      logic              flushed,
	output      logic              last
);

	logic              valid_s2;
	logic [1:0]        beat_q;
	logic              kind_s2;
	logic [7:0]        chr_s2;
	logic              rvalid_s2;
	logic [QCNT_W-1:0] fill_s2;
	logic              flushed_s2;
	logic              triple_s2;

	always_comb begin
		last        = !triple_s2 || (beat_q == 2'd2);
		emit_free   = !valid_s2 || (rsp_ready && last);
		rsp_valid   = valid_s2;
		result_kind = kind_s2;
		read_valid  = rvalid_s2;
		fill_level  = fill_s2;
		flushed     = flushed_s2;
		// Popped data arrives from the queue memory in the cycle after the pop.
		if (rvalid_s2) begin
			char_value = ram_rdata;
		end else if (beat_q == 2'd1) begin
			char_value = CH_SPACE;
		end else begin
			char_value = chr_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			beat_q   <= '0;
		end else begin
			if (emit_free) begin
				valid_s2 <= ld.load;
				beat_q   <= '0;
			end else if (rsp_ready) begin
				beat_q <= beat_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_free && ld.load) begin
			kind_s2    <= ld.kind;
			chr_s2     <= ld.chr;
			rvalid_s2  <= ld.rvalid;
			fill_s2    <= ld.fill;
			flushed_s2 <= ld.flushed;
			triple_s2  <= ld.triple;
		end
	end

endmodule

`default_nettype wire

// File: sv/scancode_to_ascii_key_buffer.sv
// Top level of the set-1 scancode translator with its character queue.
`default_nettype none

// Each request is either a keyboard scancode byte or a read of one queued
// character. A request sits in an input register, where it is decoded, the
// shift and caps state is updated and the queue memory is written or read;
// the result then moves to an output register, so a request is taken in
// every cycle while the output side keeps up. Shift, caps lock and release
// bytes produce no result and leave from the input register. A printable
// press and a read produce one result each; a backspace produces three echo
// results (backspace, space, backspace) and holds the output register until
// all three are taken, while any later request with a result waits in the
// input register. Typed characters go into a 4096-entry queue memory; when
// it fills, it is emptied at once and the results of that request carry the
// flushed flag with a fill level of zero. A read of an empty queue returns a
// reply with read_valid low and character zero. The memory needs no clearing
// after reset, since only written entries are read.
module scancode_to_ascii_key_buffer import sckb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output      logic              req_ready,
	input  wire logic              kind,
	input  wire logic [7:0]        scan_code,
	output      logic              rsp_valid,
	input  wire logic              rsp_ready,
	output      logic              result_kind,
	output      logic [7:0]        char_value,
	output      logic              read_valid,
	output      logic [QCNT_W-1:0] fill_level,
	output      logic              flushed,
	output      logic              last
);

	sckb_load_t         ld;
	logic               emit_free;
	logic               ram_we, ram_re;
	logic [QADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]         ram_wdata, ram_rdata;

	// Decode stage: owns all architectural state and drives the queue memory.
	sckb_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.kind      (kind),
		.scan_code (scan_code),
		.emit_free (emit_free),
		.ld        (ld),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	// The character queue itself.
	sckb_ram #(
		.WIDTH (8),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output stage: one result register with a beat counter for backspace.
	sckb_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.ld          (ld),
		.ram_rdata   (ram_rdata),
		.emit_free   (emit_free),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.result_kind (result_kind),
		.char_value  (char_value),
		.read_valid  (read_valid),
		.fill_level  (fill_level),
		.flushed     (flushed),
		.last        (last)
	);

	// A flush always leaves the queue empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && flushed) |-> (fill_level == '0))
		else $error("flushed result with nonzero fill level");

	// The queue never reports a fill at or above its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (fill_level < QDEPTH_CNT))
		else $error("fill level reached queue depth");

	// Echo results never carry read data, and an empty read returns zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (result_kind == RK_ECHO)) |-> !read_valid)
		else $error("echo result marked as read data");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (result_kind == RK_READ) && !read_valid) |-> (char_value == 8'h00))
		else $error("empty read returned a character");

	// The next beat of a multi-result request follows immediately.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready && !last) |=> rsp_valid)
		else $error("gap inside a backspace echo");

endmodule

`default_nettype wire

// File: tb/sckb_echo_checker.sv
// Result checker for the scancode key buffer: predicts every result and compares.
module sckb_echo_checker import sckb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  logic              kind,
	input  logic [7:0]        scan_code,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  logic              result_kind,
	input  logic [7:0]        char_value,
	input  logic              read_valid,
	input  logic [QCNT_W-1:0] fill_level,
	input  logic              flushed,
	input  logic              last,
	output int                mismatches,
	output int                outstanding,
	output int                queued_chars,
	output int                requests_seen,
	output int                results_seen,
	output int                flushes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic              rkind;
		logic [7:0]        chr;
		logic              rvalid;
		logic [QCNT_W-1:0] fill;
		logic              wiped;
		logic              last;
	} key_result_t;

	// Set-1 key table, unshifted half first; entries past the end read zero.
	localparam int KEYMAP_LEN = 180;
	localparam logic [7:0] KEYMAP [KEYMAP_LEN] = '{
		8'h00, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8",
		"9", "0", "-", "=", 8'h08, 8'h09, "q", "w", "e", "r",
		"t", "y", "u", "i", "o", "p", "[", "]", 8'h0A, 8'h00,
		"a", "s", "d", "f", "g", "h", "j", "k", "l", ";",
		8'h27, 8'h60, 8'h00, 8'h5C, "z", "x", "c", "v", "b", "n",
		"m", ",", ".", "/", 8'h00, "*", 8'h00, " ", 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, "-", 8'h00, 8'h00, 8'h00, "+", 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h1B, "!", "@", "#", "$", "%", "^", "&", "*",
		"(", ")", "_", "+", 8'h08, 8'h09, "Q", "W", "E", "R",
		"T", "Y", "U", "I", "O", "P", "{", "}", 8'h0A, 8'h00,
		"A", "S", "D", "F", "G", "H", "J", "K", "L", ":",
		8'h22, "~", 8'h00, "|", "Z", "X", "C", "V", "B", "N",
		"M", "<", ">", "?", 8'h00, "*", 8'h00, " ", 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, "-", 8'h00, 8'h00, 8'h00, "+", 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	key_result_t       expected_results[$];
	logic [7:0]        typed_chars[$];
	logic signed [4:0] shift_level;
	logic              caps_lock;

	task automatic log_mismatch(input string msg);
		$display("[%0t] key buffer check: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic move_shift(input int delta);
		int v;
		v = int'(shift_level) + delta;
		if (v > int'(SHIFT_MAX))
			v = int'(SHIFT_MAX);
		if (v < int'(SHIFT_MIN))
			v = int'(SHIFT_MIN);
		shift_level = 5'(v);
	endtask

	// Works out the results of one accepted request and updates the key state.
	task automatic predict_keystroke(input logic k, input logic [7:0] sc);
		logic [8:0]  idx;
		logic [7:0]  ch;
		logic        wiped;
		key_result_t r;
		if (k == KIND_READ) begin
			r = '{RK_READ, 8'h00, 1'b0, '0, 1'b0, 1'b1};
			if (typed_chars.size() != 0) begin
				r.chr = typed_chars.pop_front();
				r.rvalid = 1'b1;
			end
			r.fill = QCNT_W'(typed_chars.size());
			expected_results.push_back(r);
		end else if (sc[7]) begin
			if (sc[6:0] == SC_LSHIFT || sc[6:0] == SC_RSHIFT)
				move_shift(-1);
		end else if (sc[6:0] == SC_LSHIFT || sc[6:0] == SC_RSHIFT) begin
			move_shift(1);
		end else if (sc == SC_CAPS) begin
			caps_lock = !caps_lock;
			move_shift(caps_lock ? 1 : -1);
		end else begin
			if (sc == SC_BKSP) begin
				ch = CH_BS;
			end else begin
				idx = {1'b0, sc} + ((shift_level > 0) ? SHIFT_OFS : 9'd0);
				ch = (idx < KEYMAP_LEN) ? KEYMAP[idx] : 8'h00;
			end
			typed_chars.push_back(ch);
			wiped = (typed_chars.size() >= QUEUE_DEPTH);
			if (wiped)
				typed_chars.delete();
			r = '{RK_ECHO, ch, 1'b0, QCNT_W'(typed_chars.size()), wiped, 1'b1};
			if (sc == SC_BKSP) begin
				r.last = 1'b0;
				expected_results.push_back(r);
				r.chr = CH_SPACE;
				expected_results.push_back(r);
				r.chr = CH_BS;
				r.last = 1'b1;
			end
			expected_results.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		key_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			typed_chars.delete();
			shift_level = '0;
			caps_lock = 1'b0;
			mismatches = 0;
			requests_seen = 0;
			results_seen = 0;
			flushes_seen = 0;
			outstanding <= 0;
			queued_chars <= 0;
		end else begin
			// Results first: none can belong to a request taken at this same edge.
			if (rsp_valid && rsp_ready) begin
				results_seen++;
				if (flushed === 1'b1 && last === 1'b1)
					flushes_seen++;
				if (expected_results.size() == 0) begin
					log_mismatch($sformatf("result %0d arrived with nothing expected (char %0h)",
						results_seen, char_value));
				end else begin
					want = expected_results.pop_front();
					if (result_kind !== want.rkind)
						log_mismatch($sformatf("result %0d result_kind %0b, expected %0b",
							results_seen, result_kind, want.rkind));
					if (char_value !== want.chr)
						log_mismatch($sformatf("result %0d char_value %0h, expected %0h",
							results_seen, char_value, want.chr));
					if (read_valid !== want.rvalid)
						log_mismatch($sformatf("result %0d read_valid %0b, expected %0b",
							results_seen, read_valid, want.rvalid));
					if (fill_level !== want.fill)
						log_mismatch($sformatf("result %0d fill_level %0d, expected %0d",
							results_seen, fill_level, want.fill));
					if (flushed !== want.wiped)
						log_mismatch($sformatf("result %0d flushed %0b, expected %0b",
							results_seen, flushed, want.wiped));
					if (last !== want.last)
						log_mismatch($sformatf("result %0d last %0b, expected %0b",
							results_seen, last, want.last));
				end
			end
			if (req_valid && req_ready) begin
				requests_seen++;
				predict_keystroke(kind, scan_code);
			end
			outstanding <= expected_results.size();
			queued_chars <= typed_chars.size();
		end
	end

endmodule

// File: tb/scancode_to_ascii_key_buffer_tb.sv
// Testbench top for the scancode key buffer: stimulus, response stalls and verdict.
module scancode_to_ascii_key_buffer_tb import sckb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// The run is ended by force if it has not finished after this many cycles.
	localparam int CYCLE_LIMIT = 40000;
	// Random requests to send after the directed opening; together they come
	// to about 370 requests.
	localparam int RANDOM_REQUESTS = 346;
	// Cycles allowed after the last expected result for stray output to show up.
	localparam int SETTLE_CYCLES = 8;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic              kind = KIND_SCAN;
	logic [7:0]        scan_code = 8'h00;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	logic              result_kind;
	logic [7:0]        char_value;
	logic              read_valid;
	logic [QCNT_W-1:0] fill_level;
	logic              flushed;
	logic              last;

	int mismatches;
	int outstanding;
	int queued_chars;
	int requests_seen;
	int results_seen;
	int flushes_seen;

	// When calm is set neither side inserts idle cycles, so the block runs
	// back to back for a while.
	logic calm = 1'b0;
	int   counted = 0;
	int   cycle_count = 0;
	int   random_base;

	// Directed opening: each entry is {kind, scan_code}. Comments give the
	// point of each request.
	logic [8:0] warmup [24] = '{
		{KIND_READ, 8'hFF},              // read while the queue is empty
		{KIND_SCAN, 8'h00},              // table entry zero, a zero byte is queued
		{KIND_SCAN, 8'd16},              // plain letter
		{KIND_SCAN, 8'h7F},              // highest press code, unshifted
		{KIND_SCAN, SC_BKSP},            // backspace gives three echoes
		{KIND_SCAN, SC_CAPS},            // caps lock on raises the shift count
		{KIND_SCAN, 8'd30},              // shifted letter
		{KIND_SCAN, 8'h7F},              // shifted index far past the table end
		{KIND_SCAN, 8'd89},              // shifted index on the last table entry
		{KIND_SCAN, 8'd90},              // shifted index one past the table end
		{KIND_SCAN, SC_CAPS},            // caps lock off lowers the count
		{KIND_SCAN, {1'b0, SC_LSHIFT}},  // left shift press
		{KIND_SCAN, 8'd2},               // shifted digit
		{KIND_SCAN, {1'b1, SC_LSHIFT}},  // left shift release
		{KIND_SCAN, {1'b0, SC_RSHIFT}},  // right shift press
		{KIND_SCAN, {1'b1, SC_RSHIFT}},  // right shift release
		{KIND_SCAN, 8'h9E},              // release of an ordinary key is ignored
		{KIND_SCAN, 8'hFF},              // release with every bit set, also ignored
		{KIND_SCAN, {1'b1, SC_LSHIFT}},  // unmatched release drives the count negative
		{KIND_SCAN, 8'd57},              // negative count still reads the plain half
		{KIND_SCAN, {1'b0, SC_LSHIFT}},  // back to a zero count
		{KIND_READ, 8'h00},              // pops the zero byte, read_valid still high
		{KIND_READ, 8'hAA},
		{KIND_READ, 8'h55}
	};

	scancode_to_ascii_key_buffer i_dut (.*);

	sckb_echo_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The response side stalls at random, with a probability of 16 percent, unless the run is calm.
	always @(posedge clk) begin
		if (calm)
			rsp_ready <= 1'b1;
		else
			rsp_ready <= ($urandom_range(99) >= 16);
	end

	// Watchdog: a hung handshake or a lost result ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results still expected.",
				cycle_count, outstanding);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offers one request and returns at the edge where it is accepted. Valid
	// stays high from one request to the next unless an idle gap is drawn, so
	// back-to-back requests never see valid drop.
	task automatic send_key(input logic k, input logic [7:0] sc);
		while (!calm && $urandom_range(99) < 16) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		kind <= k;
		scan_code <= sc;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		counted++;
	endtask

	// A press that always queues exactly one character: any code below 128
	// except the shift keys and caps lock. Backspace turns up now and then.
	function automatic logic [7:0] plain_key();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(127));
		end while (c[6:0] == SC_LSHIFT || c[6:0] == SC_RSHIFT || c == SC_CAPS);
		return c;
	endfunction

	// Stops offering requests and waits until every predicted result is in.
	task automatic drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// One random burst. Most bursts are well-formed typing: words with or
	// without their releases, words under a held shift key, caps lock spans,
	// backspaces and reads. Some runs hammer one shift key, often until the count
	// pins at a limit, and the rest is raw noise on both fields.
	task automatic random_burst();
		int         pick;
		int         n;
		logic [7:0] c;
		logic [7:0] sh;
		pick = $urandom_range(99);
		n = $urandom_range(8, 1);
		sh = $urandom_range(1) ? {1'b0, SC_LSHIFT} : {1'b0, SC_RSHIFT};
		if (pick < 35) begin
			repeat (n) begin
				c = plain_key();
				send_key(KIND_SCAN, c);
				if ($urandom_range(1))
					send_key(KIND_SCAN, c | 8'h80);
			end
		end else if (pick < 50) begin
			send_key(KIND_SCAN, sh);
			repeat (n)
				send_key(KIND_SCAN, plain_key());
			send_key(KIND_SCAN, sh | 8'h80);
		end else if (pick < 58) begin
			send_key(KIND_SCAN, SC_CAPS);
			repeat (n)
				send_key(KIND_SCAN, plain_key());
			if ($urandom_range(3) != 0)
				send_key(KIND_SCAN, SC_CAPS);
		end else if (pick < 66) begin
			repeat ($urandom_range(3, 1))
				send_key(KIND_SCAN, SC_BKSP);
		end else if (pick < 80) begin
			repeat (n)
				send_key(KIND_READ, 8'($urandom_range(255)));
		end else if (pick < 86) begin
			// Nine to eleven moves in one direction: enough to saturate from a count at
			// most one step on the far side of zero, but never from the far limit.
			if ($urandom_range(1))
				sh = sh | 8'h80;
			repeat ($urandom_range(11, 9))
				send_key(KIND_SCAN, sh);
		end else begin
			repeat ($urandom_range(4, 1))
				send_key(1'($urandom_range(1)), 8'($urandom_range(255)));
		end
	endtask

	initial begin
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (warmup[i])
			send_key(warmup[i][8], warmup[i][7:0]);

		// Random traffic, with a calm stretch in the middle.
		random_base = counted;
		while (counted < random_base + RANDOM_REQUESTS) begin
			calm <= (counted - random_base >= 150) && (counted - random_base < 240);
			random_burst();
		end
		calm <= 1'b0;

		drain();
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		$display("Sent %0d requests (directed opening and random typing bursts), ",
			requests_seen);
		$display("checked %0d results, %0d overflow flushes, %0d characters left queued.",
			results_seen, flushes_seen, queued_chars);
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: scancode_to_ascii_key_buffer.f
sv/sckb_pkg.sv
sv/sckb_ram.sv
sv/sckb_core.sv
sv/sckb_emit.sv
sv/scancode_to_ascii_key_buffer.sv
tb/sckb_echo_checker.sv
tb/scancode_to_ascii_key_buffer_tb.sv
